### rtl/core/bly_pkg.sv
// Shared types and constants for the busy-loop yield detector.
`default_nettype none

package bly_pkg;

    // Event codes carried on the kind field
    typedef enum logic [2:0] {
        KIND_FRAME  = 3'd0,
        KIND_MISS   = 3'd1,
        KIND_HIT    = 3'd2,
        KIND_TIMER  = 3'd3,
        KIND_AUDIO  = 3'd4,
        KIND_STATUS = 3'd5,
        KIND_UPDATE = 3'd6
    } kind_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMER_LIMIT  = 1'b0,
        CFG_STATUS_LIMIT = 1'b1
    } cfg_index_t;

    localparam int KIND_W  = 3;
    localparam int CMD_W   = 32;
    localparam int FRAME_W = 32;
    localparam int CNT_W   = 8;

    localparam logic [CNT_W-1:0] TIMER_LIMIT_RST  = 8'd10;
    localparam logic [CNT_W-1:0] STATUS_LIMIT_RST = 8'd1;
    localparam logic [CNT_W-1:0] CNT_MAX          = 8'd255;

endpackage

`default_nettype wire

### rtl/core/busy_loop_yield_detector.sv
// Top level of the busy-loop yield detector: event decode, tracking state and result register.
//
// The block takes one event per transaction and returns one transaction carrying the
// yield-request flag as it stands after that event. The tracking registers and the result
// register are both loaded at the accepting edge, so the result appears on the output the
// cycle after acceptance and a new event can be accepted every cycle. The only limit on
// rate is the single result register: the input stalls only while a result is held
// there and the output is stalled. The configuration port is always ready and should be
// written only while the block is idle.
`default_nettype none

module busy_loop_yield_detector
    import bly_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [KIND_W-1:0]      kind,
    input  wire logic [CMD_W-1:0]       cmd_count,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        yield_requested,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]       cfg_data
);

    logic               accept;

    logic [CNT_W-1:0]   timer_limit_reg;
    logic [CNT_W-1:0]   status_limit_reg;

    logic [FRAME_W-1:0] frame_number_reg, frame_number_next;
    logic               yield_flag_reg, yield_flag_next;
    logic [CMD_W-1:0]   hit_cmd_reg, hit_cmd_next;
    logic               hit_valid_reg, hit_valid_next;
    logic [FRAME_W-1:0] timer_frame_reg, timer_frame_next;
    logic               timer_frame_valid_reg, timer_frame_valid_next;
    logic [CNT_W-1:0]   timer_checks_reg, timer_checks_next;
    logic [FRAME_W-1:0] audio_frame_reg, audio_frame_next;
    logic               audio_frame_valid_reg, audio_frame_valid_next;
    logic [CNT_W-1:0]   status_checks_reg, status_checks_next;
    logic [CNT_W-1:0]   timer_inc;
    logic [CNT_W-1:0]   status_inc;

    logic               out_valid_reg, out_valid_next;
    logic               out_yield_reg, out_yield_next;

    // Handshakes
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_limit_reg  <= TIMER_LIMIT_RST;
            status_limit_reg <= STATUS_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TIMER_LIMIT:  timer_limit_reg  <= cfg_data;
                CFG_STATUS_LIMIT: status_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Saturating counter increments
    assign timer_inc  = (timer_checks_reg == CNT_MAX) ? CNT_MAX : timer_checks_reg + 1'b1;
    assign status_inc = (status_checks_reg == CNT_MAX) ? CNT_MAX : status_checks_reg + 1'b1;

    // Decode the event and update tracking state
    always_comb
    begin
        frame_number_next      = frame_number_reg;
        yield_flag_next        = yield_flag_reg;
        hit_cmd_next           = hit_cmd_reg;
        hit_valid_next         = hit_valid_reg;
        timer_frame_next       = timer_frame_reg;
        timer_frame_valid_next = timer_frame_valid_reg;
        timer_checks_next      = timer_checks_reg;
        audio_frame_next       = audio_frame_reg;
        audio_frame_valid_next = audio_frame_valid_reg;
        status_checks_next     = status_checks_reg;

        unique case (kind_t'(kind))
            KIND_FRAME:
            begin
                frame_number_next = frame_number_reg + 1'b1;
                yield_flag_next   = 1'b0;
            end
            KIND_MISS:
            begin
                if (!hit_valid_reg || cmd_count != hit_cmd_reg)
                    yield_flag_next = 1'b1;
            end
            KIND_HIT:
            begin
                hit_cmd_next   = cmd_count;
                hit_valid_next = 1'b1;
            end
            KIND_TIMER:
            begin
                if (timer_frame_valid_reg && timer_frame_reg == frame_number_reg)
                begin
                    timer_checks_next = timer_inc;
                    if (timer_inc >= timer_limit_reg)
                        yield_flag_next = 1'b1;
                end
                else
                begin
                    timer_frame_next       = frame_number_reg;
                    timer_frame_valid_next = 1'b1;
                    timer_checks_next      = '0;
                end
            end
            KIND_AUDIO:
            begin
                if (audio_frame_valid_reg && audio_frame_reg == frame_number_reg)
                    yield_flag_next = 1'b1;
                audio_frame_next       = frame_number_reg;
                audio_frame_valid_next = 1'b1;
            end
            KIND_STATUS:
            begin
                if (status_inc > status_limit_reg)
                begin
                    status_checks_next = '0;
                    yield_flag_next    = 1'b1;
                end
                else
                begin
                    status_checks_next = status_inc;
                end
            end
            KIND_UPDATE:
            begin
                status_checks_next = '0;
            end
            default:
            begin
                // Unused code: hold all state
            end
        endcase
    end

    // Tracking state advances on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_number_reg      <= '0;
            yield_flag_reg        <= 1'b0;
            hit_cmd_reg           <= '0;
            hit_valid_reg         <= 1'b0;
            timer_frame_reg       <= '0;
            timer_frame_valid_reg <= 1'b0;
            timer_checks_reg      <= '0;
            audio_frame_reg       <= '0;
            audio_frame_valid_reg <= 1'b0;
            status_checks_reg     <= '0;
        end
        else if (accept)
        begin
            frame_number_reg      <= frame_number_next;
            yield_flag_reg        <= yield_flag_next;
            hit_cmd_reg           <= hit_cmd_next;
            hit_valid_reg         <= hit_valid_next;
            timer_frame_reg       <= timer_frame_next;
            timer_frame_valid_reg <= timer_frame_valid_next;
            timer_checks_reg      <= timer_checks_next;
            audio_frame_reg       <= audio_frame_next;
            audio_frame_valid_reg <= audio_frame_valid_next;
            status_checks_reg     <= status_checks_next;
        end
    end

    // Result register: load on accept, drop once taken, hold while stalled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_yield_next = out_yield_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_yield_next = yield_flag_next;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_yield_reg <= out_yield_next;
    end

    assign out_valid       = out_valid_reg;
    assign yield_requested = out_yield_reg;

    // Checks
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted event produced no result");

    a_frame_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == KIND_FRAME |=> !yield_requested)
        else $error("new frame did not clear the yield flag");

    a_miss_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == KIND_MISS && !hit_valid_reg |=> yield_requested)
        else $error("input miss before any hit did not set the yield flag");

    a_result_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> yield_requested == yield_flag_reg)
        else $error("result differs from the tracked yield flag");

endmodule

`default_nettype wire
